>>> rtl/csv_field_splitter_unit_defines.svh
// Assertion macros shared by the CSV field splitter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef CSV_FIELD_SPLITTER_UNIT_DEFINES_SVH
`define CSV_FIELD_SPLITTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSVFS_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSVFS_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/csvfs_pkg.sv
// Types and constants for the CSV field splitter.
// No dependencies; imported by every module of the block.
package csvfs_pkg;

	localparam int unsigned MAX_SEPARATORS = 4;
	localparam int unsigned NUM_SEP_REGS   = 4;
	localparam int unsigned QUEUE_DEPTH    = 4;

	localparam logic [7:0] QUOTE_CH = 8'h22;
	localparam logic [7:0] CR_CH    = 8'h0D;
	localparam logic [7:0] LF_CH    = 8'h0A;

	localparam logic [2:0] SEP_COUNT_RST  = 3'd1;
	localparam logic [7:0] SEP_BYTE_0_RST = 8'd44;

	typedef enum logic [2:0] {
		REG_SEP_COUNT  = 3'd0,
		REG_SEP_BYTE_0 = 3'd1,
		REG_SEP_BYTE_1 = 3'd2,
		REG_SEP_BYTE_2 = 3'd3,
		REG_SEP_BYTE_3 = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		REQ_TEXT  = 1'b0,
		REQ_FLUSH = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_PLAIN  = 2'd1,
		MODE_QUOTED = 2'd2,
		MODE_QSEEN  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_BYTE       = 2'd0,
		KIND_FIELD_END  = 2'd1,
		KIND_RECORD_END = 2'd2
	} kind_t;

	// Work orders passed from the parser to the output side.
	typedef enum logic [1:0] {
		OP_BYTE         = 2'd0,
		OP_FIELD_END    = 2'd1,
		OP_RECORD_END   = 2'd2,
		OP_FIELD_RECORD = 2'd3
	} op_t;

endpackage

>>> rtl/csvfs_front.sv
// Parser front end: configuration registers, separator match and parse state.
// Depends on csvfs_pkg; pushes one encoded operation per result-bearing beat.
module csvfs_front import csvfs_pkg::*; #(
	parameter int unsigned MAX_FIELDS = 1024,
	parameter int unsigned FW = $clog2(MAX_FIELDS),
	parameter int unsigned EW = 2 + 8 + FW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          req_type,
	input  logic [7:0]    ch,
	input  logic          q_full,
	output logic          push,
	output logic [EW-1:0] push_entry
);

	localparam logic [FW-1:0] FIELD_MAX = FW'(MAX_FIELDS - 1);

	logic [2:0]    sep_count_q;
	logic [7:0]    sep_byte_q [NUM_SEP_REGS];
	mode_t         mode_q, mode_d;
	logic          after_cr_q, after_cr_d;
	logic          nonempty_q, nonempty_d;
	logic [FW-1:0] fnum_q, fnum_d;
	logic [FW-1:0] fnum_inc;
	logic          accept;
	logic          is_sep;
	logic          is_eol;
	op_t           op;
	logic [7:0]    data;
	logic [FW-1:0] idx;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_eol   = (ch == CR_CH) || (ch == LF_CH);
	assign fnum_inc = (fnum_q == FIELD_MAX) ? fnum_q : fnum_q + FW'(1);

	always_comb begin
		is_sep = 1'b0;
		for (int k = 0; k < NUM_SEP_REGS; k++) begin
			if ((3'(k) < sep_count_q) && (k < MAX_SEPARATORS) && (sep_byte_q[k] == ch)) begin
				is_sep = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_count_q   <= SEP_COUNT_RST;
			sep_byte_q[0] <= SEP_BYTE_0_RST;
			sep_byte_q[1] <= '0;
			sep_byte_q[2] <= '0;
			sep_byte_q[3] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEP_COUNT:  sep_count_q   <= cfg_data[2:0];
				REG_SEP_BYTE_0: sep_byte_q[0] <= cfg_data;
				REG_SEP_BYTE_1: sep_byte_q[1] <= cfg_data;
				REG_SEP_BYTE_2: sep_byte_q[2] <= cfg_data;
				REG_SEP_BYTE_3: sep_byte_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_START;
			after_cr_q <= 1'b0;
			nonempty_q <= 1'b0;
			fnum_q     <= '0;
		end else begin
			mode_q     <= mode_d;
			after_cr_q <= after_cr_d;
			nonempty_q <= nonempty_d;
			fnum_q     <= fnum_d;
		end
	end

	always_comb begin
		mode_d     = mode_q;
		after_cr_d = after_cr_q;
		nonempty_d = nonempty_q;
		fnum_d     = fnum_q;
		push       = 1'b0;
		op         = OP_BYTE;
		data       = '0;
		idx        = fnum_q;
		if (accept) begin
			if (req_type == REQ_FLUSH) begin
				after_cr_d = 1'b0;
				if (nonempty_q) begin
					push = 1'b1;
					op   = OP_FIELD_RECORD;
				end
				mode_d     = MODE_START;
				nonempty_d = 1'b0;
				fnum_d     = '0;
			end else if (after_cr_q && (ch == LF_CH)) begin
				// The LF of a CR+LF pair has already been accounted for.
				after_cr_d = 1'b0;
			end else begin
				after_cr_d = (ch == CR_CH);
				if (is_eol) begin
					push = 1'b1;
					if (nonempty_q) begin
						op = OP_FIELD_RECORD;
					end else begin
						op  = OP_RECORD_END;
						idx = '0;
					end
					mode_d     = MODE_START;
					nonempty_d = 1'b0;
					fnum_d     = '0;
				end else begin
					nonempty_d = 1'b1;
					unique case (mode_q)
						MODE_START: begin
							if (ch == QUOTE_CH) begin
								mode_d = MODE_QUOTED;
							end else if (is_sep) begin
								push   = 1'b1;
								op     = OP_FIELD_END;
								fnum_d = fnum_inc;
							end else begin
								push   = 1'b1;
								data   = ch;
								mode_d = MODE_PLAIN;
							end
						end
						MODE_PLAIN: begin
							push = 1'b1;
							if (is_sep) begin
								op     = OP_FIELD_END;
								fnum_d = fnum_inc;
								mode_d = MODE_START;
							end else begin
								data = ch;
							end
						end
						MODE_QUOTED: begin
							if (ch == QUOTE_CH) begin
								mode_d = MODE_QSEEN;
							end else begin
								push = 1'b1;
								data = ch;
							end
						end
						MODE_QSEEN: begin
							push = 1'b1;
							if (ch == QUOTE_CH) begin
								// A doubled quote stands for one literal quote.
								data   = ch;
								mode_d = MODE_QUOTED;
							end else if (is_sep) begin
								op     = OP_FIELD_END;
								fnum_d = fnum_inc;
								mode_d = MODE_START;
							end else begin
								data   = ch;
								mode_d = MODE_PLAIN;
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	assign push_entry = {op, data, idx};

endmodule

>>> rtl/csvfs_queue.sv
// Small register queue between the parser and the output sequencer.
// Depends on csvfs_pkg for its depth and on the assertion macro header.
`include "csv_field_splitter_unit_defines.svh"
module csvfs_queue import csvfs_pkg::*; #(
	parameter int unsigned WIDTH = 20
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_entry,
	input  logic             pop,
	output logic [WIDTH-1:0] head_entry,
	output logic             full,
	output logic             empty
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;

	assign full       = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign empty      = (cnt_q == '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	`CSVFS_ASSERT_IMP(a_no_push_full, clk, arst_n, push, !full, "queue pushed while full")
	`CSVFS_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty, "queue popped while empty")
	`CSVFS_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= (AW+1)'(QUEUE_DEPTH), "queue count out of range")

endmodule

>>> rtl/csvfs_back.sv
// Output sequencer: expands queued operations into result beats.
// Depends on csvfs_pkg and on the assertion macro header.
`include "csv_field_splitter_unit_defines.svh"
module csvfs_back import csvfs_pkg::*; #(
	parameter int unsigned MAX_FIELDS = 1024,
	parameter int unsigned FW = $clog2(MAX_FIELDS),
	parameter int unsigned EW = 2 + 8 + FW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  logic [EW-1:0] q_entry,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    kind,
	output logic [7:0]    data_byte,
	output logic [FW-1:0] field_index,
	output logic          last
);

	localparam logic [FW-1:0] FIELD_MAX = FW'(MAX_FIELDS - 1);

	op_t           op;
	logic [7:0]    op_data;
	logic [FW-1:0] op_idx;
	logic [FW-1:0] op_cnt;
	logic          load;

	logic          out_valid_q;
	logic          phase_q;
	kind_t         kind_q;
	logic [7:0]    data_q;
	logic [FW-1:0] idx_q;
	logic          last_q;
	logic [FW-1:0] cnt_q;

	assign op      = op_t'(q_entry[EW-1 -: 2]);
	assign op_data = q_entry[FW +: 8];
	assign op_idx  = q_entry[FW-1:0];
	assign op_cnt  = (op_idx == FIELD_MAX) ? op_idx : op_idx + FW'(1);

	assign load = !out_valid_q || out_ready;
	assign pop  = load && !phase_q && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			if (phase_q) begin
				out_valid_q <= 1'b1;
				phase_q     <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				phase_q     <= (op == OP_FIELD_RECORD);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (phase_q) begin
				// Second beat of a record close: the field count.
				kind_q <= KIND_RECORD_END;
				data_q <= '0;
				idx_q  <= cnt_q;
				last_q <= 1'b1;
			end else if (!q_empty) begin
				data_q <= op_data;
				idx_q  <= op_idx;
				last_q <= (op != OP_FIELD_RECORD);
				cnt_q  <= op_cnt;
				unique case (op)
					OP_BYTE:         kind_q <= KIND_BYTE;
					OP_FIELD_END:    kind_q <= KIND_FIELD_END;
					OP_RECORD_END:   kind_q <= KIND_RECORD_END;
					OP_FIELD_RECORD: kind_q <= KIND_FIELD_END;
					default:         kind_q <= KIND_BYTE;
				endcase
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign data_byte   = data_q;
	assign field_index = idx_q;
	assign last        = last_q;

	`CSVFS_ASSERT_IMP(a_phase_shows_eof, clk, arst_n, phase_q, out_valid_q && (kind_q == KIND_FIELD_END) && !last_q, "pending record end without field end beat")
	`CSVFS_ASSERT_NXT(a_split_sets_phase, clk, arst_n, pop && (op == OP_FIELD_RECORD), phase_q, "record close did not schedule second beat")

endmodule

>>> rtl/csv_field_splitter_unit.sv
// Channel       | Dir | Handshake            | Payload
// input         | in  | in_valid/in_ready    | req_type, ch
// result        | out | out_valid/out_ready  | kind, data_byte, field_index, last
// configuration | in  | cfg_we (no wait)     | cfg_index, cfg_data
//
// One input beat is taken per cycle while the four-entry queue has room.
// Each result passes through the queue and then the output register; a record
// close with data gives two result beats from one queue entry.
// Reset clears parse state and loads the separator defaults (comma only).
// Output stalls fill the queue; input ready drops only when the queue is full.
module csv_field_splitter_unit import csvfs_pkg::*; #(
	parameter int unsigned MAX_FIELDS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [7:0]                    ch,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    kind,
	output logic [7:0]                    data_byte,
	output logic [$clog2(MAX_FIELDS)-1:0] field_index,
	output logic                          last
);

	localparam int unsigned FW = $clog2(MAX_FIELDS);
	localparam int unsigned EW = 2 + 8 + FW;

	logic          push;
	logic [EW-1:0] push_entry;
	logic          pop;
	logic [EW-1:0] head_entry;
	logic          q_full;
	logic          q_empty;

	csvfs_front #(
		.MAX_FIELDS(MAX_FIELDS),
		.FW(FW),
		.EW(EW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.ch(ch),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry)
	);

	csvfs_queue #(
		.WIDTH(EW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head_entry(head_entry),
		.full(q_full),
		.empty(q_empty)
	);

	csvfs_back #(
		.MAX_FIELDS(MAX_FIELDS),
		.FW(FW),
		.EW(EW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_entry(head_entry),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.data_byte(data_byte),
		.field_index(field_index),
		.last(last)
	);

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for csv_field_splitter_unit: directed and random CSV streams.
// A built-in parser model predicts every result beat and a monitor checks each one.
// Depends on csvfs_pkg and the csv_field_splitter_unit RTL.
module tb;
	import csvfs_pkg::*;

	localparam int          CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          PHASE_BEATS   = 130;
	localparam logic [9:0]  FIELD_MAX     = 10'd1023;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [9:0] field_index;
		logic       last;
	} token_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_SEP_COUNT;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       req_type = REQ_TEXT;
	logic [7:0] ch = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [9:0] field_index;
	logic       last;

	// Parser model state and its copy of the separator registers.
	logic [2:0] active_seps;
	logic [7:0] sep_char [4];
	mode_t      pmode;
	logic       cr_pending;
	logic       rec_has_bytes;
	logic [9:0] cur_field;

	token_t pending_tokens [$];
	token_t step_tokens [$];

	int errors = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int beats_sent = 0;

	csv_field_splitter_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.ch          (ch),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.data_byte   (data_byte),
		.field_index (field_index),
		.last        (last)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : check_results
		token_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_tokens.size() == 0) begin
				report_mismatch("unexpected result beat, kind", kind, -1);
			end else begin
				want = pending_tokens.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", kind, want.kind);
				if (data_byte !== want.data_byte)
					report_mismatch("data_byte", data_byte, want.data_byte);
				if (field_index !== want.field_index)
					report_mismatch("field_index", field_index, want.field_index);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
			end
		end
	end

	// ---------------- parser model ----------------

	task automatic reset_model();
		active_seps = SEP_COUNT_RST;
		sep_char[0] = SEP_BYTE_0_RST;
		sep_char[1] = 8'h00;
		sep_char[2] = 8'h00;
		sep_char[3] = 8'h00;
		pmode = MODE_START;
		cr_pending = 1'b0;
		rec_has_bytes = 1'b0;
		cur_field = '0;
	endtask

	function automatic bit is_separator(logic [7:0] c);
		for (int k = 0; k < 4; k++) begin
			if (k < active_seps && k < MAX_SEPARATORS && sep_char[k] == c)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic emit(kind_t k, logic [7:0] d, logic [9:0] idx);
		token_t t;
		t.kind = k;
		t.data_byte = d;
		t.field_index = idx;
		t.last = 1'b0;
		step_tokens = {step_tokens, t};
	endtask

	task automatic end_field();
		emit(KIND_FIELD_END, 8'h00, cur_field);
		if (cur_field < FIELD_MAX)
			cur_field++;
		pmode = MODE_START;
	endtask

	task automatic close_record();
		if (rec_has_bytes) begin
			emit(KIND_FIELD_END, 8'h00, cur_field);
			emit(KIND_RECORD_END, 8'h00,
				(cur_field == FIELD_MAX) ? FIELD_MAX : cur_field + 10'd1);
		end else begin
			emit(KIND_RECORD_END, 8'h00, 10'd0);
		end
		pmode = MODE_START;
		rec_has_bytes = 1'b0;
		cur_field = '0;
	endtask

	// Advances the model by one accepted beat and queues the results it causes.
	task automatic parse_beat(req_t r, logic [7:0] c);
		token_t t;
		step_tokens.delete();
		if (r == REQ_FLUSH) begin
			cr_pending = 1'b0;
			if (rec_has_bytes)
				close_record();
			pmode = MODE_START;
			cur_field = '0;
		end else if (cr_pending && c == LF_CH) begin
			cr_pending = 1'b0;
		end else begin
			cr_pending = 1'b0;
			if (c == CR_CH || c == LF_CH) begin
				close_record();
				cr_pending = (c == CR_CH);
			end else begin
				rec_has_bytes = 1'b1;
				case (pmode)
					MODE_START: begin
						// A leading quote opens a quoted field even if it is also a separator.
						if (c == QUOTE_CH)
							pmode = MODE_QUOTED;
						else if (is_separator(c))
							end_field();
						else begin
							emit(KIND_BYTE, c, cur_field);
							pmode = MODE_PLAIN;
						end
					end
					MODE_PLAIN: begin
						if (is_separator(c))
							end_field();
						else
							emit(KIND_BYTE, c, cur_field);
					end
					MODE_QUOTED: begin
						if (c == QUOTE_CH)
							pmode = MODE_QSEEN;
						else
							emit(KIND_BYTE, c, cur_field);
					end
					default: begin
						if (c == QUOTE_CH) begin
							emit(KIND_BYTE, c, cur_field);
							pmode = MODE_QUOTED;
						end else if (is_separator(c)) begin
							end_field();
						end else begin
							emit(KIND_BYTE, c, cur_field);
							pmode = MODE_PLAIN;
						end
					end
				endcase
			end
		end
		while (step_tokens.size() != 0) begin
			t = step_tokens.pop_front();
			if (step_tokens.size() == 0)
				t.last = 1'b1;
			pending_tokens = {pending_tokens, t};
		end
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic send_beat(req_t r, logic [7:0] c);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r;
		ch <= c;
		do
			@(posedge clk);
		while (!in_ready);
		parse_beat(r, c);
		beats_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(REQ_TEXT, s[i]);
	endtask

	// Stops sending and waits until every predicted result beat has been seen.
	task automatic settle(int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic program_seps(logic [7:0] cnt_word, logic [7:0] b0, logic [7:0] b1,
		logic [7:0] b2, logic [7:0] b3);
		cfg_reg_t   regs [5];
		logic [7:0] vals [5];
		regs = '{REG_SEP_COUNT, REG_SEP_BYTE_0, REG_SEP_BYTE_1, REG_SEP_BYTE_2, REG_SEP_BYTE_3};
		vals = '{cnt_word, b0, b1, b2, b3};
		settle(SETTLE_CYCLES);
		for (int k = 0; k < 5; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		active_seps = cnt_word[2:0];
		sep_char[0] = b0;
		sep_char[1] = b1;
		sep_char[2] = b2;
		sep_char[3] = b3;
	endtask

	function automatic logic [7:0] pick_sep();
		int n;
		n = (active_seps > MAX_SEPARATORS) ? MAX_SEPARATORS : active_seps;
		if (n == 0)
			return ",";
		return sep_char[$urandom_range(0, n - 1)];
	endfunction

	function automatic logic [7:0] text_byte();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(8'h61, 8'h7A));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] random_sep_char();
		case ($urandom_range(0, 5))
			0: return ",";
			1: return ";";
			2: return 8'h09;
			3: return "|";
			4: return " ";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_record();
		int nf;
		int len;
		int sel;
		nf = $urandom_range(0, 5);
		for (int f = 0; f < nf; f++) begin
			if (f > 0)
				send_beat(REQ_TEXT, pick_sep());
			sel = $urandom_range(0, 9);
			len = $urandom_range(0, 4);
			if (sel < 6) begin
				for (int i = 0; i < len; i++)
					send_beat(REQ_TEXT, text_byte());
			end else if (sel < 9) begin
				send_beat(REQ_TEXT, QUOTE_CH);
				for (int i = 0; i < len; i++) begin
					case ($urandom_range(0, 4))
						0: begin
							send_beat(REQ_TEXT, QUOTE_CH);
							send_beat(REQ_TEXT, QUOTE_CH);
						end
						1: send_beat(REQ_TEXT, pick_sep());
						default: send_beat(REQ_TEXT, text_byte());
					endcase
				end
				send_beat(REQ_TEXT, QUOTE_CH);
				if ($urandom_range(0, 3) == 0)
					send_beat(REQ_TEXT, text_byte());
			end else begin
				send_beat(REQ_TEXT, 8'($urandom_range(0, 255)));
			end
		end
		sel = $urandom_range(0, 9);
		if (sel < 3)
			send_beat(REQ_TEXT, LF_CH);
		else if (sel < 6)
			send_beat(REQ_TEXT, CR_CH);
		else if (sel < 9) begin
			send_beat(REQ_TEXT, CR_CH);
			send_beat(REQ_TEXT, LF_CH);
		end else
			send_beat(REQ_FLUSH, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_beat(REQ_FLUSH, 8'($urandom_range(0, 255)));
			else begin
				case ($urandom_range(0, 5))
					0: send_beat(REQ_TEXT, QUOTE_CH);
					1: send_beat(REQ_TEXT, CR_CH);
					2: send_beat(REQ_TEXT, LF_CH);
					3: send_beat(REQ_TEXT, pick_sep());
					default: send_beat(REQ_TEXT, 8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	// ---------------- tests ----------------

	// Reset separators (comma only): quoting, line ends, empty records and flushes.
	task automatic test_default_parse();
		send_beat(REQ_TEXT, 8'h00);
		send_text(",\",\"\"\"x");
		send_beat(REQ_TEXT, 8'hFF);
		send_text(",");
		send_beat(REQ_TEXT, CR_CH);
		send_beat(REQ_TEXT, LF_CH);
		send_beat(REQ_TEXT, LF_CH);
		send_text("\"q");
		send_beat(REQ_TEXT, CR_CH);
		send_beat(REQ_TEXT, LF_CH);
		send_beat(REQ_FLUSH, 8'hFF);
		send_text("z");
		send_beat(REQ_FLUSH, 8'h00);
		send_beat(REQ_TEXT, CR_CH);
		send_beat(REQ_FLUSH, 8'h55);
		send_beat(REQ_TEXT, LF_CH);
	endtask

	task automatic test_separator_sets();
		// No separators: the whole line is a single field.
		program_seps(8'd0, ",", ";", 8'h00, 8'hFF);
		send_text("a,b;c");
		send_beat(REQ_TEXT, CR_CH);
		send_text("\"x,\"y");
		send_beat(REQ_TEXT, LF_CH);
		// Oversized count with the quote, CR and 0xFF in the separator set.
		program_seps(8'd7, QUOTE_CH, ",", CR_CH, 8'hFF);
		send_text("\"a\",\"\"b\"c");
		send_beat(REQ_TEXT, 8'hFF);
		send_text("q\"x");
		send_beat(REQ_TEXT, CR_CH);
		send_beat(REQ_TEXT, LF_CH);
		program_seps(8'd5, 8'h00, ";", 8'h09, LF_CH);
		send_text("a");
		send_beat(REQ_TEXT, 8'h00);
		send_text("b;\t");
		send_beat(REQ_TEXT, LF_CH);
		program_seps(8'd4, ";", 8'h09, "|", ",");
		send_text("a;b\tc|d,e");
		send_beat(REQ_TEXT, LF_CH);
		// Upper bits of the count word are not part of the register.
		program_seps(8'hFA, ",", ";", "|", 8'h09);
		send_text("1,2;3|4");
		send_beat(REQ_TEXT, CR_CH);
		send_beat(REQ_TEXT, LF_CH);
	endtask

	// A record with more separators than the field counter can hold.
	task automatic test_field_overflow();
		program_seps(8'd1, ",", 8'h00, 8'h00, 8'h00);
		send_text("a");
		repeat (1030) send_beat(REQ_TEXT, ",");
		send_text("b");
		send_beat(REQ_TEXT, LF_CH);
	endtask

	task automatic test_random_streams();
		int idle_set  [4];
		int stall_set [4];
		int phase_end;
		int cnt_sel;
		logic [2:0] cnt;
		bit paused;
		idle_set  = '{0, 72, 0, 35};
		stall_set = '{0, 0, 72, 35};
		for (int p = 0; p < 4; p++) begin
			cnt_sel = $urandom_range(0, 9);
			if (cnt_sel == 0)
				cnt = 3'd0;
			else if (cnt_sel < 5)
				cnt = 3'd1;
			else if (cnt_sel < 7)
				cnt = 3'd2;
			else if (cnt_sel == 7)
				cnt = 3'd3;
			else if (cnt_sel == 8)
				cnt = 3'd4;
			else
				cnt = 3'($urandom_range(5, 7));
			program_seps({5'($urandom_range(0, 31)), cnt}, random_sep_char(),
				random_sep_char(), random_sep_char(), random_sep_char());
			idle_pct = idle_set[p];
			stall_pct = stall_set[p];
			phase_end = beats_sent + PHASE_BEATS;
			paused = 1'b0;
			while (beats_sent < phase_end) begin
				if ($urandom_range(0, 7) == 0)
					send_noise();
				else
					send_record();
				// Hold the sender until the result side has fully caught up.
				if (!paused && beats_sent > phase_end - PHASE_BEATS / 2) begin
					settle(0);
					paused = 1'b1;
				end
			end
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic finish_run();
		settle(SETTLE_CYCLES);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	endtask

	initial begin
		reset_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_parse();
		test_separator_sets();
		test_field_overflow();
		test_random_streams();
		finish_run();
	end

endmodule
